// File: design/sni_pkg.sv
// Shared types, constants and the microcode program of the shaped noise injector.
// Used by sni_datapath and shaped_noise_injector; depends on nothing else.
package sni_pkg;

  // Sample and arithmetic widths
  localparam int SAMPLE_W = 24;
  localparam int HIST_N   = 3;              // FIR taps past the fixed unity tap
  localparam int COEF_W   = 16;
  localparam int GATE_W   = 16;
  localparam int MUL_A_W  = 36;
  localparam int MUL_B_W  = 18;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 2 * SAMPLE_W - 6;  // three 16x24 products summed
  localparam int SUM_W    = 32;
  localparam int Q12_SH   = 12;
  localparam int NOISE_SH = 16 + 32 - SAMPLE_W; // gate scaling plus Q1.31 to sample

  // LCG constants; the multiplier is applied in two 16-bit halves
  localparam logic [31:0] LCG_SEED   = 32'hDEADBEEF;
  localparam logic [15:0] LCG_MUL_LO = 16'h4E6D;
  localparam logic [15:0] LCG_MUL_HI = 16'h41C6;
  localparam logic [31:0] LCG_INC    = 32'd12345;

  // Gate envelope constants
  localparam logic signed [SAMPLE_W-1:0] GATE_THRESH =
      SAMPLE_W'((2 ** (SAMPLE_W - 1)) / 2000);
  localparam logic [MUL_B_W-1:0] GATE_ATTACK_K  = MUL_B_W'(33);
  localparam logic [MUL_B_W-1:0] GATE_RELEASE_K = MUL_B_W'(6554);
  localparam logic [GATE_W-1:0]  GATE_FULL      = '1;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_NOISE_GAIN = 3'd1,
    REG_TILT_GAIN  = 3'd2,
    REG_TAP_ONE    = 3'd3,
    REG_TAP_TWO    = 3'd4,
    REG_TAP_THREE  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic                     enable;
    logic [COEF_W-1:0]        noise_gain;
    logic signed [COEF_W-1:0] tilt_gain;
    logic signed [COEF_W-1:0] tap_one;
    logic signed [COEF_W-1:0] tap_two;
    logic signed [COEF_W-1:0] tap_three;
  } cfg_t;

  // Multiplier operand selects
  typedef enum logic [2:0] {
    A_GATE, A_LCG, A_NOISE, A_SCALED, A_HIST0, A_HIST1, A_HIST2, A_DIFF
  } a_sel_t;

  typedef enum logic [3:0] {
    B_GATE, B_LCG_LO, B_LCG_HI, B_GAIN, B_INV_GATE, B_TAP1, B_TAP2, B_TAP3, B_TILT
  } b_sel_t;

  // Register writeback ops
  typedef enum logic [3:0] {
    WB_NONE, WB_CAPTURE, WB_GATE, WB_LCG_LO, WB_LCG, WB_ACC_LD, WB_ACC_ADD,
    WB_NOISE, WB_FILT, WB_LAST, WB_OUT_MIX, WB_OUT_PASS
  } wb_t;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_PASS = 4'd13;

  // One control word per step
  typedef struct packed {
    logic            accept;   // wait here for an input item
    logic            emit;     // write the output register, wait while it is full
    logic            fin;      // return to idle
    logic            jmp_dis;  // jump to target when disabled
    logic [PC_W-1:0] target;
    logic            mul_en;
    a_sel_t          a_sel;
    b_sel_t          b_sel;
    wb_t             wb;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   go;   // step completes this cycle
  } sni_ctl_t;

  // Microcode program
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uc;
    uc = '{accept: 1'b0, emit: 1'b0, fin: 1'b0, jmp_dis: 1'b0, target: PC_IDLE,
           mul_en: 1'b0, a_sel: A_GATE, b_sel: B_GATE, wb: WB_NONE};
    unique case (pc)
      4'd0: begin
        uc.accept = 1'b1; uc.wb = WB_CAPTURE;
      end
      4'd1: begin
        uc.jmp_dis = 1'b1; uc.target = PC_PASS;
        uc.mul_en = 1'b1; uc.a_sel = A_GATE; uc.b_sel = B_GATE;
      end
      4'd2: begin
        uc.wb = WB_GATE; uc.mul_en = 1'b1; uc.a_sel = A_LCG; uc.b_sel = B_LCG_LO;
      end
      4'd3: begin
        uc.wb = WB_LCG_LO; uc.mul_en = 1'b1; uc.a_sel = A_LCG; uc.b_sel = B_LCG_HI;
      end
      4'd4: begin
        uc.wb = WB_LCG; uc.mul_en = 1'b1; uc.a_sel = A_HIST0; uc.b_sel = B_TAP1;
      end
      4'd5: begin
        uc.wb = WB_ACC_LD; uc.mul_en = 1'b1; uc.a_sel = A_NOISE; uc.b_sel = B_GAIN;
      end
      4'd6: begin
        uc.mul_en = 1'b1; uc.a_sel = A_SCALED; uc.b_sel = B_INV_GATE;
      end
      4'd7: begin
        uc.wb = WB_NOISE; uc.mul_en = 1'b1; uc.a_sel = A_HIST1; uc.b_sel = B_TAP2;
      end
      4'd8: begin
        uc.wb = WB_ACC_ADD; uc.mul_en = 1'b1; uc.a_sel = A_HIST2; uc.b_sel = B_TAP3;
      end
      4'd9: begin
        uc.wb = WB_ACC_ADD;
      end
      4'd10: begin
        uc.wb = WB_FILT;
      end
      4'd11: begin
        uc.wb = WB_LAST; uc.mul_en = 1'b1; uc.a_sel = A_DIFF; uc.b_sel = B_TILT;
      end
      4'd12: begin
        uc.wb = WB_OUT_MIX; uc.emit = 1'b1; uc.fin = 1'b1;
      end
      4'd13: begin
        uc.wb = WB_OUT_PASS; uc.emit = 1'b1; uc.fin = 1'b1;
      end
      default: begin
        uc.fin = 1'b1;
      end
    endcase
    return uc;
  endfunction

  // Clamp to the signed sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/sni_datapath.sv
// Datapath of the shaped noise injector: one shared 36x18 multiplier, the LCG,
// gate, FIR history, tilt memory and output register. Depends on sni_pkg.
module sni_datapath import sni_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sni_ctl_t                   ctl,
  input  cfg_t                       cfg,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       block_start,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  logic signed [SAMPLE_W-1:0] x_r;
  logic [31:0]                lcg_r;
  logic [31:0]                lcg_lo_r;
  logic [GATE_W-1:0]          gate_r;
  logic signed [SAMPLE_W-1:0] hist_r [HIST_N];
  logic signed [SAMPLE_W-1:0] last_r;
  logic signed [SAMPLE_W-1:0] noise_r;
  logic signed [SAMPLE_W-1:0] filt_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SAMPLE_W-1:0] y_r;

  logic                       above;
  logic signed [31:0]         noise_q;
  logic [GATE_W:0]            inv_gate;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic [32:0]                gate_sum;
  logic [GATE_W-1:0]          gate_step;
  logic signed [SUM_W-1:0]    filt_sum;
  logic signed [SUM_W-1:0]    y_sum;

  // Gate detector and operand helpers
  assign above    = (x_r > GATE_THRESH) || (x_r < -GATE_THRESH);
  assign noise_q  = {~lcg_r[30], lcg_r[29:0], 1'b0};  // 2*(v & 0x7FFFFFFF) - 2^31
  assign inv_gate = {1'b1, {GATE_W{1'b0}}} - {1'b0, gate_r};
  assign diff     = {filt_r[SAMPLE_W-1], filt_r} - {last_r[SAMPLE_W-1], last_r};

  // Operand A select
  always_comb begin
    case (ctl.uc.a_sel)
      A_GATE:   mul_a = above ? {{(MUL_A_W-GATE_W){1'b0}}, GATE_FULL - gate_r}
                              : {{(MUL_A_W-GATE_W){1'b0}}, gate_r};
      A_LCG:    mul_a = {{(MUL_A_W-32){1'b0}}, lcg_r};
      A_NOISE:  mul_a = {{(MUL_A_W-32){noise_q[31]}}, noise_q};
      A_SCALED: mul_a = prod_r[MUL_A_W+Q12_SH-1:Q12_SH];
      A_HIST0:  mul_a = {{(MUL_A_W-SAMPLE_W){hist_r[0][SAMPLE_W-1]}}, hist_r[0]};
      A_HIST1:  mul_a = {{(MUL_A_W-SAMPLE_W){hist_r[1][SAMPLE_W-1]}}, hist_r[1]};
      A_HIST2:  mul_a = {{(MUL_A_W-SAMPLE_W){hist_r[2][SAMPLE_W-1]}}, hist_r[2]};
      A_DIFF:   mul_a = {{(MUL_A_W-SAMPLE_W-1){diff[SAMPLE_W]}}, diff};
      default:  mul_a = '0;
    endcase
  end

  // Operand B select
  always_comb begin
    case (ctl.uc.b_sel)
      B_GATE:     mul_b = above ? GATE_ATTACK_K : GATE_RELEASE_K;
      B_LCG_LO:   mul_b = {2'b00, LCG_MUL_LO};
      B_LCG_HI:   mul_b = {2'b00, LCG_MUL_HI};
      B_GAIN:     mul_b = {2'b00, cfg.noise_gain};
      B_INV_GATE: mul_b = {1'b0, inv_gate};
      B_TAP1:     mul_b = {{2{cfg.tap_one[COEF_W-1]}}, cfg.tap_one};
      B_TAP2:     mul_b = {{2{cfg.tap_two[COEF_W-1]}}, cfg.tap_two};
      B_TAP3:     mul_b = {{2{cfg.tap_three[COEF_W-1]}}, cfg.tap_three};
      B_TILT:     mul_b = {{2{cfg.tilt_gain[COEF_W-1]}}, cfg.tilt_gain};
      default:    mul_b = '0;
    endcase
  end

  // Gate step: ceil(p / 65536)
  assign gate_sum  = {1'b0, prod_r[31:0]} + 33'd65535;
  assign gate_step = gate_sum[31:16];

  // FIR sum plus noise, and final mix
  assign filt_sum = {{(SUM_W-SAMPLE_W){noise_r[SAMPLE_W-1]}}, noise_r}
                  + {{(SUM_W-ACC_W+Q12_SH){acc_r[ACC_W-1]}}, acc_r[ACC_W-1:Q12_SH]};
  assign y_sum = {{(SUM_W-SAMPLE_W){x_r[SAMPLE_W-1]}}, x_r}
               + {{(SUM_W-SAMPLE_W){filt_r[SAMPLE_W-1]}}, filt_r}
               + {{(SUM_W-SAMPLE_W-5){prod_r[SAMPLE_W+Q12_SH+4]}},
                  prod_r[SAMPLE_W+Q12_SH+4:Q12_SH]};

  // Noise state: LCG, gate, history, tilt memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcg_r  <= LCG_SEED;
      gate_r <= '0;
      last_r <= '0;
      for (int k = 0; k < HIST_N; k++) begin
        hist_r[k] <= '0;
      end
    end else if (ctl.go) begin
      case (ctl.uc.wb)
        WB_CAPTURE: begin
          if (block_start) begin
            last_r <= '0;
            for (int k = 0; k < HIST_N; k++) begin
              hist_r[k] <= '0;
            end
          end
        end
        WB_GATE: begin
          gate_r <= above ? gate_r + gate_step : gate_r - gate_step;
        end
        WB_LCG: begin
          lcg_r <= lcg_lo_r + {prod_r[15:0], 16'h0000} + LCG_INC;
        end
        WB_FILT: begin
          hist_r[0] <= noise_r;
          for (int k = 1; k < HIST_N; k++) begin
            hist_r[k] <= hist_r[k-1];
          end
        end
        WB_LAST: begin
          last_r <= filt_r;
        end
        default: ;
      endcase
    end
  end

  // Working registers, product register and output register
  always_ff @(posedge clk) begin
    if (ctl.go) begin
      if (ctl.uc.mul_en) begin
        prod_r <= mul_a * mul_b;
      end
      case (ctl.uc.wb)
        WB_CAPTURE:  x_r      <= sample_in;
        WB_LCG_LO:   lcg_lo_r <= prod_r[31:0];
        WB_ACC_LD:   acc_r    <= prod_r[ACC_W-1:0];
        WB_ACC_ADD:  acc_r    <= acc_r + prod_r[ACC_W-1:0];
        WB_NOISE:    noise_r  <= sat_sample({{(SUM_W-PROD_W+NOISE_SH){prod_r[PROD_W-1]}},
                                             prod_r[PROD_W-1:NOISE_SH]});
        WB_FILT:     filt_r   <= sat_sample(filt_sum);
        WB_OUT_MIX:  y_r      <= sat_sample(y_sum);
        WB_OUT_PASS: y_r      <= x_r;
        default: ;
      endcase
    end
  end

  assign sample_out = y_r;

endmodule

// File: design/shaped_noise_injector.sv
// Top level of the shaped noise injector: configuration registers, microcode
// sequencer and stream handshakes. Depends on sni_pkg and sni_datapath.
//
// Adds gated, FIR-shaped and tilted LCG noise to a stream of signed Q0.23
// samples, one result per input item. With enable set the next item is taken
// only after the current one's output step: a microcoded sequencer runs
// all nine products (gate step, two LCG halves, noise gain, gate scaling, three
// FIR taps, tilt) one per cycle through a single 36x18 multiplier. With enable
// clear items skip to the pass-through step. A finished item waits in the output
// register; the next item is accepted meanwhile and only stalls at its own
// output step if that register is still full. in_tuser set on an item clears the
// FIR history and tilt memory before that item is processed, enabled or not.
// Registers sit on the APB port at byte addresses 0x00 (enable), 0x04
// (noise_gain), 0x08 (tilt_gain), 0x0C..0x14 (tap_one..tap_three); write them
// only while the block is idle.
module shaped_noise_injector import sni_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,   // [23:0] sample_in
  input  logic                in_tuser,   // [0] block_start
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [SAMPLE_W-1:0] out_tdata,  // [23:0] sample_out
  // configuration
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  cfg_t                       cfg_r;
  logic [PC_W-1:0]            pc_r, pc_nxt;
  logic                       out_valid_r, out_valid_nxt;
  ucode_t                     uc;
  sni_ctl_t                   ctl;
  logic                       in_fire;
  logic                       out_busy;
  logic                       cfg_wr;
  reg_idx_t                   cfg_idx;
  logic signed [SAMPLE_W-1:0] sample_out;

  // Register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable     <= 1'b0;
      cfg_r.noise_gain <= 16'd4096;
      cfg_r.tilt_gain  <= '0;
      cfg_r.tap_one    <= '0;
      cfg_r.tap_two    <= '0;
      cfg_r.tap_three  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ENABLE:     cfg_r.enable     <= cfg_pwdata[0];
        REG_NOISE_GAIN: cfg_r.noise_gain <= cfg_pwdata[COEF_W-1:0];
        REG_TILT_GAIN:  cfg_r.tilt_gain  <= cfg_pwdata[COEF_W-1:0];
        REG_TAP_ONE:    cfg_r.tap_one    <= cfg_pwdata[COEF_W-1:0];
        REG_TAP_TWO:    cfg_r.tap_two    <= cfg_pwdata[COEF_W-1:0];
        REG_TAP_THREE:  cfg_r.tap_three  <= cfg_pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_idx)
      REG_ENABLE:     cfg_prdata = {31'd0, cfg_r.enable};
      REG_NOISE_GAIN: cfg_prdata = {16'd0, cfg_r.noise_gain};
      REG_TILT_GAIN:  cfg_prdata = {16'd0, cfg_r.tilt_gain};
      REG_TAP_ONE:    cfg_prdata = {16'd0, cfg_r.tap_one};
      REG_TAP_TWO:    cfg_prdata = {16'd0, cfg_r.tap_two};
      REG_TAP_THREE:  cfg_prdata = {16'd0, cfg_r.tap_three};
      default:        cfg_prdata = '0;
    endcase
  end

  // Sequencer: fetch, hold conditions, next step
  assign uc        = ucode_rom(pc_r);
  assign in_tready = uc.accept;
  assign in_fire   = in_tvalid && in_tready;
  assign out_busy  = out_valid_r && !out_tready;

  always_comb begin
    ctl.uc = uc;
    if (uc.accept) begin
      ctl.go = in_fire;
    end else if (uc.emit) begin
      ctl.go = !out_busy;
    end else begin
      ctl.go = 1'b1;
    end

    if (!ctl.go) begin
      pc_nxt = pc_r;
    end else if (uc.jmp_dis && !cfg_r.enable) begin
      pc_nxt = uc.target;
    end else if (uc.fin) begin
      pc_nxt = PC_IDLE;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end

    if (uc.emit && ctl.go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  sni_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .cfg         (cfg_r),
    .sample_in   (in_tdata),
    .block_start (in_tuser),
    .sample_out  (sample_out)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = sample_out;

endmodule

// File: design/sni_checker.sv
// Port-level checks for shaped_noise_injector, attached by the bind below.
// Depends only on the top level's port list.
module sni_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // One item at a time: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready again right after an accept");

  // A new result leaves the sequencer back at idle
  a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("sequencer not idle after producing a result");

endmodule

bind shaped_noise_injector sni_checker u_sni_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: verif/tb_shaped_noise_injector.sv
// Self-checking testbench for shaped_noise_injector: streams Q0.23 samples with
// random idling on both sides and checks every result against a cycle-free
// model of the gate, LCG, FIR and tilt path. Depends on sni_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_shaped_noise_injector;
  import sni_pkg::*;

  localparam int  STALL_LIMIT = 1000;   // cycles without any handshake
  localparam int  TAIL_CYCLES = 20;
  localparam int  LOUD_RUN    = 250;    // no-idle loud stretch that pushes the gate well up
  localparam longint GATE_LIMIT = (64'sd1 <<< (SAMPLE_W - 1)) / 2000;
  localparam longint FULL_HI    = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
  localparam longint FULL_LO    = -FULL_HI - 1;

  typedef enum logic {OP_SAMPLE, OP_WRITE} op_kind_t;
  typedef enum int {MIX_LOUD, MIX_QUIET, MIX_ANY} level_mix_t;

  typedef struct {
    op_kind_t            kind;
    logic [SAMPLE_W-1:0] smp;
    logic                blk;
    logic                no_idle;
    reg_idx_t            idx;
    logic [31:0]         value;
  } pending_op_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata    = '0;    // [23:0] sample_in
  logic                in_tuser    = 1'b0;  // [0] block_start
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [SAMPLE_W-1:0] out_tdata;           // [23:0] sample_out
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [4:0]          cfg_paddr   = '0;
  logic [31:0]         cfg_pwdata  = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  pending_op_t         pending[$];
  logic [SAMPLE_W-1:0] expected_samples[$];
  logic                burst_mode = 1'b0;
  int                  outstanding;
  int                  quiet_cycles;
  int                  fail_count = 0;
  int                  idle_cycles = 0;

  // Model state and shadow registers
  logic [31:0]         lcg_state;
  int unsigned         gate_env;
  longint              noise_hist[HIST_N];
  longint              prev_filtered;
  logic                sh_enable;
  logic [15:0]         sh_gain;
  logic signed [15:0]  sh_tilt;
  logic signed [15:0]  sh_tap[HIST_N];

  shaped_noise_injector u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  function automatic longint clamp_sample(input longint v);
    if (v > FULL_HI) return FULL_HI;
    if (v < FULL_LO) return FULL_LO;
    return v;
  endfunction

  // One sample through gate, LCG, gain, FIR, tilt and the final mix
  function automatic logic [SAMPLE_W-1:0] shape_sample(input logic [SAMPLE_W-1:0] smp,
                                                       input logic blk);
    longint x, ax, n, acc, filt, tilted, y;
    x = $signed(smp);
    if (blk) begin
      noise_hist = '{default: 0};
      prev_filtered = 0;
    end
    if (!sh_enable) return smp;

    ax = (x < 0) ? -x : x;
    if (ax > GATE_LIMIT) begin
      gate_env += ((65535 - gate_env) * 33 + 65535) >> 16;
    end else begin
      gate_env -= (gate_env * 6554 + 65535) >> 16;
    end

    lcg_state = lcg_state * 32'd1103515245 + 32'd12345;
    n = longint'(lcg_state & 32'h7FFF_FFFF) * 2 - 64'sh8000_0000;
    n = (n * longint'(sh_gain)) >>> 12;
    n = (n * (65536 - longint'(gate_env))) >>> 16;
    n = clamp_sample(n >>> (32 - SAMPLE_W));

    acc = 0;
    for (int k = 0; k < HIST_N; k++) acc += longint'(sh_tap[k]) * noise_hist[k];
    filt = clamp_sample(n + (acc >>> 12));
    for (int k = HIST_N - 1; k > 0; k--) noise_hist[k] = noise_hist[k - 1];
    noise_hist[0] = n;

    tilted = filt + ((longint'(sh_tilt) * (filt - prev_filtered)) >>> 12);
    prev_filtered = filt;
    y = clamp_sample(x + tilted);
    return y[SAMPLE_W-1:0];
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic blk,
                             input logic no_idle);
    pending_op_t op;
    op = '{kind: OP_SAMPLE, smp: smp, blk: blk, no_idle: no_idle,
           idx: REG_ENABLE, value: '0};
    pending.push_back(op);
  endtask

  task automatic push_write(input reg_idx_t idx, input logic [31:0] value);
    pending_op_t op;
    op = '{kind: OP_WRITE, smp: '0, blk: 1'b0, no_idle: 1'b0, idx: idx, value: value};
    pending.push_back(op);
  endtask

  task automatic write_all(input logic en, input logic [15:0] gain, input logic [15:0] tilt,
                           input logic [15:0] t1, input logic [15:0] t2,
                           input logic [15:0] t3);
    push_write(REG_ENABLE, {31'd0, en});
    push_write(REG_NOISE_GAIN, {16'd0, gain});
    push_write(REG_TILT_GAIN, {16'd0, tilt});
    push_write(REG_TAP_ONE, {16'd0, t1});
    push_write(REG_TAP_TWO, {16'd0, t2});
    push_write(REG_TAP_THREE, {16'd0, t3});
  endtask

  // Sample above, below or anywhere around the gate threshold
  function automatic logic [SAMPLE_W-1:0] pick_sample(input level_mix_t mix);
    int                  mag;
    int                  sel;
    logic [SAMPLE_W-1:0] s;
    sel = $urandom_range(7);
    case (mix)
      MIX_LOUD: begin
        mag = (sel == 0) ? 8388608 : $urandom_range(8388607, 4195);
      end
      MIX_QUIET: begin
        mag = (sel == 0) ? $urandom_range(4194, 4180) : $urandom_range(4194, 0);
      end
      default: begin
        if (sel < 4) return SAMPLE_W'($urandom());
        mag = (sel == 4) ? 8388608 : ((sel == 5) ? 8388607 : $urandom_range(4196, 4192));
      end
    endcase
    s = SAMPLE_W'(mag);
    return $urandom_range(1) ? -s : s;
  endfunction

  // Runs of loud, quiet or mixed material so the gate swings through its range
  task automatic fill_runs(input int count);
    int         left;
    int         len;
    level_mix_t mix;
    left = count;
    while (left > 0) begin
      len = $urandom_range(60, 1);
      mix = level_mix_t'($urandom_range(2));
      for (int i = 0; i < len && left > 0; i++) begin
        push_sample(pick_sample(mix), $urandom_range(39) == 0, 1'b0);
        left--;
      end
    end
  endtask

  function automatic logic [15:0] rand_coef();
    return $urandom_range(1) ? 16'($urandom_range(16'hFFFF))
                             : 16'($signed(16'($urandom_range(16'h1FFF))) - 16'sh1000);
  endfunction

  // Input driver and register writes, fed from the pending queue
  always @(posedge clk) begin
    logic take;
    if (!rst_n) begin
      in_tvalid   <= 1'b0;
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
      burst_mode  <= 1'b0;
      outstanding  = 0;
      quiet_cycles = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        void'(pending.pop_front());
        outstanding++;
      end
      if (out_tvalid && out_tready) outstanding--;
      quiet_cycles = (outstanding == 0) ? quiet_cycles + 1 : 0;

      if (cfg_psel && cfg_penable) begin
        // access phase completes at this edge
        void'(pending.pop_front());
        cfg_psel    <= 1'b0;
        cfg_penable <= 1'b0;
        cfg_pwrite  <= 1'b0;
      end else if (cfg_psel) begin
        cfg_penable <= 1'b1;
      end else if (in_tvalid && !in_tready) begin
        // hold the item until taken
      end else if (pending.size() != 0 && pending[0].kind == OP_SAMPLE) begin
        take = pending[0].no_idle || ($urandom_range(99) >= 38);
        in_tvalid <= take;
        if (take) begin
          in_tdata   <= pending[0].smp;
          in_tuser   <= pending[0].blk;
          burst_mode <= pending[0].no_idle;
        end
      end else begin
        in_tvalid <= 1'b0;
        // registers change only once the block has drained
        if (pending.size() != 0 && outstanding == 0 && quiet_cycles >= 4) begin
          cfg_psel   <= 1'b1;
          cfg_pwrite <= 1'b1;
          cfg_paddr  <= {pending[0].idx, 2'b00};
          cfg_pwdata <= pending[0].value;
        end
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= burst_mode || ($urandom_range(99) >= 38);
    end
  end

  // Monitor: track register writes, predict on input, compare on output
  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_ENABLE:     sh_enable = cfg_pwdata[0];
          REG_NOISE_GAIN: sh_gain   = cfg_pwdata[15:0];
          REG_TILT_GAIN:  sh_tilt   = cfg_pwdata[15:0];
          REG_TAP_ONE:    sh_tap[0] = cfg_pwdata[15:0];
          REG_TAP_TWO:    sh_tap[1] = cfg_pwdata[15:0];
          REG_TAP_THREE:  sh_tap[2] = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_samples.push_back(shape_sample(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          if (fail_count < 10) $display("unexpected item: sample_out=%h", out_tdata);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (out_tdata !== want) begin
            if (fail_count < 10) begin
              $display("mismatch: sample_out expected %h, got %h", want, out_tdata);
            end
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // model state after reset
    lcg_state     = LCG_SEED;
    gate_env      = 0;
    noise_hist    = '{default: 0};
    prev_filtered = 0;
    sh_enable     = 1'b0;
    sh_gain       = 16'd4096;
    sh_tilt       = '0;
    sh_tap        = '{default: '0};

    // pass-through at reset values, block start while disabled
    push_sample(24'h7FFFFF, 1'b0, 1'b0);
    push_sample(24'h800000, 1'b0, 1'b0);
    push_sample(24'h000000, 1'b1, 1'b0);

    // maximum gain and extreme coefficients (tap_two negative), samples around the gate threshold
    write_all(1'b1, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF);
    push_sample(24'h7FFFFF, 1'b0, 1'b0);
    push_sample(24'h800000, 1'b0, 1'b0);
    push_sample(SAMPLE_W'(4194), 1'b0, 1'b0);
    push_sample(SAMPLE_W'(4195), 1'b0, 1'b0);
    push_sample(SAMPLE_W'(-4194), 1'b0, 1'b0);
    push_sample(SAMPLE_W'(-4195), 1'b0, 1'b0);
    push_sample(24'h000000, 1'b1, 1'b0);
    push_sample(24'h123456, 1'b0, 1'b0);
    push_sample(24'hEDCBA9, 1'b0, 1'b0);

    // zero gain and negative extremes
    write_all(1'b1, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    push_sample(24'h7FFFFF, 1'b0, 1'b0);
    push_sample(24'h800000, 1'b1, 1'b0);
    push_sample(24'h000001, 1'b0, 1'b0);

    // random phases under several register settings
    for (int p = 0; p < 7; p++) begin
      case (p)
        1: write_all(1'b0, rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
        2: write_all(1'b1, 16'h0000, rand_coef(), rand_coef(), rand_coef(), rand_coef());
        3: write_all(1'b1, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        4: write_all(1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        default: begin
          write_all(1'b1, $urandom_range(1) ? 16'($urandom_range(16'h1FFF))
                                            : 16'($urandom_range(16'hFFFF)),
                    rand_coef(), rand_coef(), rand_coef(), rand_coef());
        end
      endcase
      fill_runs(200);

      if (p == 3) begin
        // loud stretch without idling raises the gate, then release to zero
        write_all(1'b1, 16'd4096, rand_coef(), rand_coef(), rand_coef(), rand_coef());
        for (int i = 0; i < LOUD_RUN; i++) begin
          push_sample(pick_sample(MIX_LOUD), $urandom_range(499) == 0, 1'b1);
        end
        for (int i = 0; i < 100; i++) push_sample(pick_sample(MIX_QUIET), 1'b0, 1'b0);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || expected_samples.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0 && expected_samples.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
